>>> src/etsel_pkg.sv
// Shared types and constants for the elite top-k selector.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package etsel_pkg;

   localparam int FIT_W       = 32;  // signed Q16.16 fitness
   localparam int IDX_W       = 6;   // population index
   localparam int EC_W        = 7;   // elite_count register
   localparam int POP_MAX_DEF = 64;

   typedef struct packed {
      logic signed [FIT_W-1:0] fitness;
      logic                    end_of_population;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0] elite_index;
      logic             final_elite;
   } rsp_type;

   // Running best candidate handed from cell to cell.
   typedef struct packed {
      logic signed [FIT_W-1:0] best;
      logic [IDX_W-1:0]        idx;
   } cand_type;

   // Control from the sequencer to every cell.
   typedef struct packed {
      logic             load;     // write fitness into the cell at sel_idx
      logic             mark;     // set chosen bit of the cell at sel_idx
      logic             clear;    // clear all chosen bits
      logic [IDX_W-1:0] sel_idx;
   } cell_ctrl_type;

endpackage

>>> src/etsel_cell.sv
// One cell of the selection chain: holds one fitness and its chosen bit,
// and registers the running best candidate. Depends on etsel_pkg.
`timescale 1ns / 1ps

module etsel_cell #(
   parameter int CELL_IDX = 0,
   parameter int CW       = 7
) (
   input  logic                          clock,
   input  logic                          reset,
   input  etsel_pkg::cell_ctrl_type      ctrl,
   input  logic signed [etsel_pkg::FIT_W-1:0] wr_fitness,
   input  logic [CW-1:0]                 loaded_count,
   input  etsel_pkg::cand_type           cand_prev,
   output etsel_pkg::cand_type           cand_next
);
   import etsel_pkg::*;

   logic signed [FIT_W-1:0] fit_ff, fit_in;
   logic                    chosen_ff, chosen_in;
   cand_type                cand_ff, cand_in;
   logic                    selected;
   logic                    active;

   assign selected = (ctrl.sel_idx == IDX_W'(CELL_IDX));
   assign active   = (loaded_count > CW'(CELL_IDX));

   always_comb begin
      fit_in = fit_ff;
      if (ctrl.load && selected) begin
         fit_in = wr_fitness;
      end

      chosen_in = chosen_ff;
      if (ctrl.clear) begin
         chosen_in = 1'b0;
      end else if (ctrl.mark && selected) begin
         chosen_in = 1'b1;
      end

      // strict greater-than keeps the earliest index on ties
      cand_in = cand_prev;
      if (active && !chosen_ff && (fit_ff > cand_prev.best)) begin
         cand_in.best = fit_ff;
         cand_in.idx  = IDX_W'(CELL_IDX);
      end
   end

   always_ff @(posedge clock) begin
      fit_ff  <= fit_in;
      cand_ff <= cand_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chosen_ff <= 1'b0;
      end else begin
         chosen_ff <= chosen_in;
      end
   end

   assign cand_next = cand_ff;

endmodule

>>> src/elite_topk_selector.sv
// Top level of the elite top-k selector: sequencer, output register and
// the chain of etsel_cell instances. Depends on etsel_pkg and etsel_cell.
`timescale 1ns / 1ps

//  channel | ports                      | direction | transaction
//  --------+----------------------------+-----------+------------------------------
//  req     | req_valid/ready, req_data  | in        | one fitness, end mark
//  rsp     | rsp_valid/ready, rsp_data  | out       | one elite index, final flag
//  csr     | csr_valid/ready, csr_data  | in        | elite_count write
//
//  Loading accepts one req transaction per cycle while idle. The end mark starts a
//  pass of k rounds unless k is zero; each round runs the candidate through the
//  POP_MAX-cell chain in the scan state, then emits one elite in the emit state;
//  a stalled rsp holds the emit state.
//  req_ready is low for the whole pass. csr_ready is always high.
//  Synchronous active-high reset; no clearing pass is needed after it.

module elite_topk_selector #(
   parameter int POP_MAX = etsel_pkg::POP_MAX_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  etsel_pkg::req_type            req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output etsel_pkg::rsp_type            rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [etsel_pkg::EC_W-1:0]    csr_data
);
   import etsel_pkg::*;

   localparam int CW = $clog2(POP_MAX + 1);  // loaded count, rounds left
   localparam int SW = $clog2(POP_MAX);      // scan cycle counter

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [SW-1:0]    scan_ff, scan_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    left_ff, left_in;
   logic [IDX_W-1:0] prev_ff, prev_in;
   logic [EC_W-1:0]  elite_ff, elite_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic [CW-1:0]    load_n;   // population size once this item is stored
   logic [CW-1:0]    pass_k;   // rounds for the pass
   cell_ctrl_type    ctrl;
   cand_type         cand [POP_MAX+1];
   cand_type         tail;

   // Head of the chain: best starts at zero; if no cell beats zero, fall back to the previous pick.
   assign cand[0].best = '0;
   assign cand[0].idx  = prev_ff;
   assign tail         = cand[POP_MAX];

   for (genvar i = 0; i < POP_MAX; i++) begin : g_cell
      etsel_cell #(
         .CELL_IDX (i),
         .CW       (CW)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (ctrl),
         .wr_fitness   (req_data.fitness),
         .loaded_count (count_ff),
         .cand_prev    (cand[i]),
         .cand_next    (cand[i+1])
      );
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Overflow items are dropped but their end mark still counts.
   assign load_n = (count_ff < CW'(POP_MAX)) ? CW'(count_ff + 1'b1) : count_ff;
   // k: elite_count, or half the population when it asks for all of it or more
   assign pass_k = (elite_ff >= EC_W'(load_n)) ? (load_n >> 1) : CW'(elite_ff);

   always_comb begin
      state_in     = state_ff;
      scan_in      = scan_ff;
      count_in     = count_ff;
      left_in      = left_ff;
      prev_in      = prev_ff;
      elite_in     = elite_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      ctrl         = '0;
      ctrl.sel_idx = IDX_W'(count_ff);

      if (csr_valid) begin
         elite_in = csr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctrl.load = (count_ff < CW'(POP_MAX));
               count_in  = load_n;
               if (req_data.end_of_population) begin
                  if (pass_k == '0) begin
                     count_in = '0;
                  end else begin
                     state_in = ST_SCAN;
                     scan_in  = '0;
                     left_in  = pass_k;
                     prev_in  = '0;
                  end
               end
            end
         end
         ST_SCAN: begin
            scan_in = SW'(scan_ff + 1'b1);
            if (scan_ff == SW'(POP_MAX - 1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.elite_index = tail.idx;
               rsp_data_in.final_elite = (left_ff == CW'(1));
               prev_in                 = tail.idx;
               left_in                 = CW'(left_ff - 1'b1);
               if (left_ff == CW'(1)) begin
                  // pass done: drop marks and start a fresh population
                  ctrl.clear = 1'b1;
                  count_in   = '0;
                  state_in   = ST_IDLE;
               end else begin
                  ctrl.mark    = 1'b1;
                  ctrl.sel_idx = tail.idx;
                  scan_in      = '0;
                  state_in     = ST_SCAN;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scan_ff      <= '0;
         count_ff     <= '0;
         left_ff      <= '0;
         prev_ff      <= '0;
         elite_ff     <= EC_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         count_ff     <= count_in;
         left_ff      <= left_in;
         prev_ff      <= prev_in;
         elite_ff     <= elite_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   // never more stored than the chain holds
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(POP_MAX))
      else $error("loaded count beyond POP_MAX");

   // a pass in progress always has a round left
   a_rounds_left: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN || state_ff == ST_EMIT) |-> (left_ff != '0))
      else $error("pass running with no rounds left");

   // the chain only ever names a loaded individual
   a_pick_loaded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> ({1'b0, tail.idx} < EC_W'(count_ff)))
      else $error("elite index outside population");

   // the final elite of a pass returns the block to loading an empty population
   a_pass_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && rsp_valid_in && !rsp_valid_ff && rsp_data_in.final_elite)
      |=> (state_ff == ST_IDLE && count_ff == '0))
      else $error("pass did not end cleanly");

endmodule
